FILE: sv/dpu_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dpu_pkg
// Shared types, register map, reset values and color constants for the
// depth pixel unprojection block.
// ----------------------------------------------------------------------------
package dpu_pkg;

	localparam int DIM_W   = 13;
	localparam int POS_W   = 12;
	localparam int CAP_W   = 25;
	localparam int SCALE_W = 24;
	localparam int PRINC_W = 16;
	localparam int INV_W   = 32;
	localparam int DEPTH_W = 16;
	localparam int PIX_W   = 8;
	localparam int COORD_W = 48;
	localparam int Z_W     = 32;
	localparam int RGBA_W  = 32;
	localparam int INDEX_W = 24;
	localparam int CLR_W   = 20;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	localparam logic [DIM_W-1:0]   RST_FRAME_WIDTH    = 13'd640;
	localparam logic [DIM_W-1:0]   RST_FRAME_HEIGHT   = 13'd480;
	localparam logic [CAP_W-1:0]   RST_POINT_CAPACITY = 25'd307200;
	localparam logic [SCALE_W-1:0] RST_DEPTH_SCALE    = 24'd1678;
	localparam logic [PRINC_W-1:0] RST_PRINCIPAL_X    = 16'd5120;
	localparam logic [PRINC_W-1:0] RST_PRINCIPAL_Y    = 16'd3840;
	localparam logic [INV_W-1:0]   RST_INV_FOCAL_X    = 32'd10000000;
	localparam logic [INV_W-1:0]   RST_INV_FOCAL_Y    = 32'd10000000;

	localparam logic signed [CLR_W-1:0] K_Y     = 20'sd298;
	localparam logic signed [CLR_W-1:0] K_RV    = 20'sd409;
	localparam logic signed [CLR_W-1:0] K_GU    = 20'sd100;
	localparam logic signed [CLR_W-1:0] K_GV    = 20'sd208;
	localparam logic signed [CLR_W-1:0] K_BU    = 20'sd516;
	localparam logic signed [CLR_W-1:0] K_HALF  = 20'sd128;
	localparam logic signed [CLR_W-1:0] K_LUMA0 = 20'sd16;
	localparam logic [RGBA_W-1:0]       WHITE   = 32'hFFFF_FFFF;
	localparam logic [PIX_W-1:0]        OPAQUE  = 8'hFF;

	typedef enum logic [2:0] {
		REG_FRAME_WIDTH,
		REG_FRAME_HEIGHT,
		REG_POINT_CAPACITY,
		REG_DEPTH_SCALE,
		REG_PRINCIPAL_X,
		REG_PRINCIPAL_Y,
		REG_INV_FOCAL_X,
		REG_INV_FOCAL_Y
	} dpu_reg_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_ZMUL,
		BK_TMUL,
		BK_IMUL,
		BK_ROUND
	} dpu_bk_state_t;

	typedef struct packed {
		logic [DIM_W-1:0]   frame_width;
		logic [DIM_W-1:0]   frame_height;
		logic [CAP_W-1:0]   point_capacity;
		logic [SCALE_W-1:0] depth_scale;
		logic [PRINC_W-1:0] principal_x;
		logic [PRINC_W-1:0] principal_y;
		logic [INV_W-1:0]   inv_focal_x;
		logic [INV_W-1:0]   inv_focal_y;
	} dpu_cfg_t;

	typedef struct packed {
		logic [DEPTH_W-1:0] depth_raw;
		logic [PIX_W-1:0]   luma_sample;
		logic [PIX_W-1:0]   chroma_u;
		logic [PIX_W-1:0]   chroma_v;
		logic               has_color;
		logic [POS_W-1:0]   column;
		logic [POS_W-1:0]   row;
		logic [INDEX_W-1:0] index;
		logic               last;
	} dpu_item_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] point_x;
		logic signed [COORD_W-1:0] point_y;
		logic [Z_W-1:0]            point_z;
		logic [RGBA_W-1:0]         color_rgba;
		logic [INDEX_W-1:0]        point_index;
		logic                      last_point;
	} dpu_point_t;

	function automatic logic [PIX_W-1:0] clip8(input logic signed [CLR_W-1:0] v);
		logic [CLR_W-1:0] s;
		begin
			s = unsigned'(v) >> 8;
			if (v < 0) begin
				clip8 = '0;
			end else if (s > CLR_W'(255)) begin
				clip8 = '1;
			end else begin
				clip8 = s[PIX_W-1:0];
			end
		end
	endfunction

endpackage
`default_nettype wire

FILE: sv/dpu_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dpu_queue
// Short queue of classified items between the front and the back.
// ----------------------------------------------------------------------------
module dpu_queue
	import dpu_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      wr_en,
	input  wire dpu_item_t wr_item,
	output logic           full,
	input  wire logic      rd_en,
	output dpu_item_t      rd_item,
	output logic           empty
);

	localparam logic [QPTR_W:0] DEPTH_C = (QPTR_W+1)'(QUEUE_DEPTH);

	dpu_item_t         mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;
	logic              do_wr;
	logic              do_rd;

	assign full    = (count_q == DEPTH_C);
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

endmodule
`default_nettype wire

FILE: sv/dpu_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dpu_front
// Pixel counters and classification: tags each pixel with its column, row,
// point index and end flag, and drops pixels past the point capacity.
// ----------------------------------------------------------------------------
module dpu_front
	import dpu_pkg::*;
#(
	parameter int MAX_FRAME_DIM = 4096
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire dpu_cfg_t           cfg,
	input  wire logic               push,
	output logic                    full,
	input  wire logic [DEPTH_W-1:0] depth_raw,
	input  wire logic [PIX_W-1:0]   luma_sample,
	input  wire logic [PIX_W-1:0]   chroma_u,
	input  wire logic [PIX_W-1:0]   chroma_v,
	input  wire logic               has_color,
	output logic                    q_wr,
	output dpu_item_t               q_item,
	input  wire logic               q_full
);

	localparam int CW = $clog2(MAX_FRAME_DIM);
	localparam logic [DIM_W-1:0] MAX_DIM = DIM_W'(MAX_FRAME_DIM);

	logic [CW-1:0]    col_q;
	logic [CW-1:0]    row_q;
	logic [CAP_W-1:0] pts_q;
	logic [DIM_W-1:0] w_lim;
	logic [DIM_W-1:0] h_lim;
	logic             row_end;
	logic             frame_end;
	logic             emit;
	logic             cap_end;
	logic             accept;

	always_comb begin
		if (cfg.frame_width == '0) begin
			w_lim = DIM_W'(1);
		end else if (cfg.frame_width > MAX_DIM) begin
			w_lim = MAX_DIM;
		end else begin
			w_lim = cfg.frame_width;
		end
		if (cfg.frame_height == '0) begin
			h_lim = DIM_W'(1);
		end else if (cfg.frame_height > MAX_DIM) begin
			h_lim = MAX_DIM;
		end else begin
			h_lim = cfg.frame_height;
		end
	end

	assign full      = q_full;
	assign accept    = push && !q_full;
	assign row_end   = (DIM_W'(col_q) + DIM_W'(1)) >= w_lim;
	assign frame_end = row_end && ((DIM_W'(row_q) + DIM_W'(1)) >= h_lim);
	assign emit      = pts_q < cfg.point_capacity;
	assign cap_end   = ((CAP_W+1)'(pts_q) + (CAP_W+1)'(1)) >= (CAP_W+1)'(cfg.point_capacity);

	assign q_wr                = accept && emit;
	assign q_item.depth_raw    = depth_raw;
	assign q_item.luma_sample  = luma_sample;
	assign q_item.chroma_u     = chroma_u;
	assign q_item.chroma_v     = chroma_v;
	assign q_item.has_color    = has_color;
	assign q_item.column       = POS_W'(col_q);
	assign q_item.row          = POS_W'(row_q);
	assign q_item.index        = pts_q[INDEX_W-1:0];
	assign q_item.last         = frame_end || cap_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			pts_q <= '0;
		end else if (accept) begin
			if (frame_end) begin
				col_q <= '0;
				row_q <= '0;
				pts_q <= '0;
			end else begin
				if (row_end) begin
					col_q <= '0;
					row_q <= row_q + 1'b1;
				end else begin
					col_q <= col_q + 1'b1;
				end
				if (emit) begin
					pts_q <= pts_q + 1'b1;
				end
			end
		end
	end

endmodule
`default_nettype wire

FILE: sv/dpu_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dpu_back
// Point arithmetic sequencer: depth scaling, color conversion, projection
// products and rounding, then a one-entry result register.
// ----------------------------------------------------------------------------
module dpu_back
	import dpu_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire dpu_cfg_t  cfg,
	input  wire dpu_item_t q_item,
	input  wire logic      q_empty,
	output logic           q_rd,
	output logic           out_valid,
	output dpu_point_t     out_point,
	input  wire logic      out_pop
);

	localparam int P_W = DEPTH_W + SCALE_W;
	localparam int T_W = Z_W + PRINC_W;
	localparam int M_W = T_W + PRINC_W;
	localparam int O_W = PRINC_W + 1;
	localparam int R_W = M_W - 19;

	dpu_bk_state_t state_q;
	dpu_bk_state_t state_d;
	logic          out_load;

	dpu_item_t          item_q;
	logic [Z_W-1:0]     z_q;
	logic [RGBA_W-1:0]  rgba_q;
	logic [PRINC_W-1:0] magx_q;
	logic [PRINC_W-1:0] magy_q;
	logic               negx_q;
	logic               negy_q;
	logic [T_W-1:0]     tx_q;
	logic [T_W-1:0]     ty_q;
	logic [M_W-1:0]     hix_q;
	logic [M_W-1:0]     lox_q;
	logic [M_W-1:0]     hiy_q;
	logic [M_W-1:0]     loy_q;
	logic               out_valid_q;
	dpu_point_t         out_q;

	logic [P_W-1:0]          prod_z;
	logic [P_W:0]            prod_zr;
	logic [P_W-8:0]          z_wide;
	logic signed [O_W-1:0]   offx;
	logic signed [O_W-1:0]   offy;
	logic signed [O_W-1:0]   offx_abs;
	logic signed [O_W-1:0]   offy_abs;
	logic signed [CLR_W-1:0] cc;
	logic signed [CLR_W-1:0] dd;
	logic signed [CLR_W-1:0] ee;
	logic signed [CLR_W-1:0] r_sum;
	logic signed [CLR_W-1:0] g_sum;
	logic signed [CLR_W-1:0] b_sum;
	logic [M_W-1:0]          mx;
	logic [M_W-1:0]          my;
	logic [R_W-1:0]          rx;
	logic [R_W-1:0]          ry;
	logic [COORD_W-1:0]      px;
	logic [COORD_W-1:0]      py;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		q_rd     = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				if (!q_empty) begin
					q_rd    = 1'b1;
					state_d = BK_ZMUL;
				end
			end
			BK_ZMUL:  state_d = BK_TMUL;
			BK_TMUL:  state_d = BK_IMUL;
			BK_IMUL:  state_d = BK_ROUND;
			BK_ROUND: begin
				if (!out_valid_q || out_pop) begin
					out_load = 1'b1;
					state_d  = BK_IDLE;
				end
			end
			default:  state_d = BK_IDLE;
		endcase
	end

	assign prod_z  = P_W'(item_q.depth_raw) * P_W'(cfg.depth_scale);
	assign prod_zr = (P_W+1)'(prod_z) + (P_W+1)'(128);
	assign z_wide  = prod_zr[P_W:8];

	assign offx     = signed'({1'b0, item_q.column, 4'b0000}) - signed'({1'b0, cfg.principal_x});
	assign offy     = signed'({1'b0, item_q.row, 4'b0000}) - signed'({1'b0, cfg.principal_y});
	assign offx_abs = offx[O_W-1] ? -offx : offx;
	assign offy_abs = offy[O_W-1] ? -offy : offy;

	assign cc    = signed'(CLR_W'(item_q.luma_sample)) - K_LUMA0;
	assign dd    = signed'(CLR_W'(item_q.chroma_u)) - K_HALF;
	assign ee    = signed'(CLR_W'(item_q.chroma_v)) - K_HALF;
	assign r_sum = K_Y * cc + K_RV * ee + K_HALF;
	assign g_sum = K_Y * cc - K_GU * dd - K_GV * ee + K_HALF;
	assign b_sum = K_Y * cc + K_BU * dd + K_HALF;

	assign mx = hix_q + (lox_q >> 16);
	assign my = hiy_q + (loy_q >> 16);
	assign rx = mx[M_W-1:20] + R_W'(mx[19]);
	assign ry = my[M_W-1:20] + R_W'(my[19]);
	assign px = negx_q ? -COORD_W'(rx) : COORD_W'(rx);
	assign py = negy_q ? -COORD_W'(ry) : COORD_W'(ry);

	always_ff @(posedge clk) begin
		if (q_rd) begin
			item_q <= q_item;
		end
		if (state_q == BK_ZMUL) begin
			z_q    <= z_wide[P_W-8] ? '1 : z_wide[Z_W-1:0];
			magx_q <= offx_abs[PRINC_W-1:0];
			magy_q <= offy_abs[PRINC_W-1:0];
			negx_q <= offx[O_W-1];
			negy_q <= !offy[O_W-1];
			rgba_q <= item_q.has_color ?
				{OPAQUE, clip8(b_sum), clip8(g_sum), clip8(r_sum)} : WHITE;
		end
		if (state_q == BK_TMUL) begin
			tx_q <= T_W'(z_q) * T_W'(magx_q);
			ty_q <= T_W'(z_q) * T_W'(magy_q);
		end
		if (state_q == BK_IMUL) begin
			hix_q <= M_W'(tx_q) * M_W'(cfg.inv_focal_x[INV_W-1:16]);
			lox_q <= M_W'(tx_q) * M_W'(cfg.inv_focal_x[15:0]);
			hiy_q <= M_W'(ty_q) * M_W'(cfg.inv_focal_y[INV_W-1:16]);
			loy_q <= M_W'(ty_q) * M_W'(cfg.inv_focal_y[15:0]);
		end
		if (out_load) begin
			out_q.point_x     <= signed'(px);
			out_q.point_y     <= signed'(py);
			out_q.point_z     <= z_q;
			out_q.color_rgba  <= rgba_q;
			out_q.point_index <= item_q.index;
			out_q.last_point  <= item_q.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_pop) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_point = out_q;

endmodule
`default_nettype wire

FILE: sv/depth_pixel_unprojection.sv
`default_nettype none
// ----------------------------------------------------------------------------
// depth_pixel_unprojection
// Pinhole depth-to-point-cloud unprojection with YUV-to-RGBA color.
//
//   channel   handshake              payload
//   pixel     push / full            depth_raw luma_sample chroma_u chroma_v has_color
//   point     empty / pop            point_x point_y point_z color_rgba point_index last_point
//   config    psel penable pwrite    paddr pwdata prdata pready
//
// A pixel is taken while the two-entry item queue has room. A pixel past the point
// capacity is taken but yields no point. Each point passes through the arithmetic
// sequencer steps in order (depth scale, offset product, focal products, round),
// and the sequencer reads no new item from the queue until that point is loaded
// into the result register. Reset clears the counters and loads the register defaults.
// A full result register stalls the sequencer, then the queue, then push.
// ----------------------------------------------------------------------------
module depth_pixel_unprojection
	import dpu_pkg::*;
#(
	parameter int MAX_FRAME_DIM = 4096
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      psel,
	input  wire logic                      penable,
	input  wire logic                      pwrite,
	input  wire logic [4:0]                paddr,
	input  wire logic [31:0]               pwdata,
	output logic      [31:0]               prdata,
	output logic                           pready,
	input  wire logic                      push,
	output logic                           full,
	input  wire logic [DEPTH_W-1:0]        depth_raw,
	input  wire logic [PIX_W-1:0]          luma_sample,
	input  wire logic [PIX_W-1:0]          chroma_u,
	input  wire logic [PIX_W-1:0]          chroma_v,
	input  wire logic                      has_color,
	output logic                           empty,
	input  wire logic                      pop,
	output logic signed [COORD_W-1:0]      point_x,
	output logic signed [COORD_W-1:0]      point_y,
	output logic      [Z_W-1:0]            point_z,
	output logic      [RGBA_W-1:0]         color_rgba,
	output logic      [INDEX_W-1:0]        point_index,
	output logic                           last_point
);

	dpu_cfg_t   cfg_q;
	dpu_reg_t   reg_sel;
	logic       cfg_wr;
	logic       q_wr;
	dpu_item_t  q_wr_item;
	logic       q_full;
	logic       q_rd;
	dpu_item_t  q_rd_item;
	logic       q_empty;
	logic       out_valid;
	dpu_point_t out_point;

	assign pready  = 1'b1;
	assign reg_sel = dpu_reg_t'(paddr[4:2]);
	assign cfg_wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_width    <= RST_FRAME_WIDTH;
			cfg_q.frame_height   <= RST_FRAME_HEIGHT;
			cfg_q.point_capacity <= RST_POINT_CAPACITY;
			cfg_q.depth_scale    <= RST_DEPTH_SCALE;
			cfg_q.principal_x    <= RST_PRINCIPAL_X;
			cfg_q.principal_y    <= RST_PRINCIPAL_Y;
			cfg_q.inv_focal_x    <= RST_INV_FOCAL_X;
			cfg_q.inv_focal_y    <= RST_INV_FOCAL_Y;
		end else if (cfg_wr) begin
			unique case (reg_sel)
				REG_FRAME_WIDTH:    cfg_q.frame_width    <= pwdata[DIM_W-1:0];
				REG_FRAME_HEIGHT:   cfg_q.frame_height   <= pwdata[DIM_W-1:0];
				REG_POINT_CAPACITY: cfg_q.point_capacity <= pwdata[CAP_W-1:0];
				REG_DEPTH_SCALE:    cfg_q.depth_scale    <= pwdata[SCALE_W-1:0];
				REG_PRINCIPAL_X:    cfg_q.principal_x    <= pwdata[PRINC_W-1:0];
				REG_PRINCIPAL_Y:    cfg_q.principal_y    <= pwdata[PRINC_W-1:0];
				REG_INV_FOCAL_X:    cfg_q.inv_focal_x    <= pwdata;
				REG_INV_FOCAL_Y:    cfg_q.inv_focal_y    <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			REG_FRAME_WIDTH:    prdata = 32'(cfg_q.frame_width);
			REG_FRAME_HEIGHT:   prdata = 32'(cfg_q.frame_height);
			REG_POINT_CAPACITY: prdata = 32'(cfg_q.point_capacity);
			REG_DEPTH_SCALE:    prdata = 32'(cfg_q.depth_scale);
			REG_PRINCIPAL_X:    prdata = 32'(cfg_q.principal_x);
			REG_PRINCIPAL_Y:    prdata = 32'(cfg_q.principal_y);
			REG_INV_FOCAL_X:    prdata = cfg_q.inv_focal_x;
			REG_INV_FOCAL_Y:    prdata = cfg_q.inv_focal_y;
			default:            prdata = '0;
		endcase
	end

	dpu_front #(
		.MAX_FRAME_DIM(MAX_FRAME_DIM)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.push        (push),
		.full        (full),
		.depth_raw   (depth_raw),
		.luma_sample (luma_sample),
		.chroma_u    (chroma_u),
		.chroma_v    (chroma_v),
		.has_color   (has_color),
		.q_wr        (q_wr),
		.q_item      (q_wr_item),
		.q_full      (q_full)
	);

	dpu_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_wr),
		.wr_item (q_wr_item),
		.full    (q_full),
		.rd_en   (q_rd),
		.rd_item (q_rd_item),
		.empty   (q_empty)
	);

	dpu_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_item    (q_rd_item),
		.q_empty   (q_empty),
		.q_rd      (q_rd),
		.out_valid (out_valid),
		.out_point (out_point),
		.out_pop   (pop)
	);

	assign empty       = !out_valid;
	assign point_x     = out_point.point_x;
	assign point_y     = out_point.point_y;
	assign point_z     = out_point.point_z;
	assign color_rgba  = out_point.color_rgba;
	assign point_index = out_point.point_index;
	assign last_point  = out_point.last_point;

endmodule
`default_nettype wire
